[rtl/ssa_pkg.sv]
// Shared types and codes for the swap slot allocator.
`default_nettype none

package ssa_pkg;

  typedef enum logic [1:0] {
    CMD_STORE  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } ssa_cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } ssa_status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] page_key;
  } ssa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] start_sector;
  } ssa_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic pop;
    logic issue;
    logic full;
    logic missing;
    logic nop;
    logic scan_start;
    logic store_pop;
    logic resolve;
    logic emit;
  } ssa_ctl_t;

  // datapath -> controller
  typedef struct packed {
    ssa_cmd_e cmd;
    logic     free_empty;
    logic     can_issue;
    logic     none_issued;
    logic     scan_done;
    logic     out_free;
  } ssa_sts_t;

endpackage

`default_nettype wire

[rtl/ssa_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/ssa_ctrl.sv]
// Sequencer for the swap slot allocator: one request at a time.
`default_nettype none

module ssa_ctrl
  import ssa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire ssa_sts_t sts_i,
  output ssa_ctl_t      ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd) inside
          CMD_STORE: begin
            if (!sts_i.free_empty) begin
              ctl_o.pop = 1'b1;
              state_d   = S_POP;
            end else if (sts_i.can_issue) begin
              ctl_o.issue = 1'b1;
              state_d     = S_FINISH;
            end else begin
              ctl_o.full = 1'b1;
              state_d    = S_FINISH;
            end
          end
          CMD_LOAD, CMD_DELETE: begin
            if (sts_i.none_issued) begin
              ctl_o.missing = 1'b1;
              state_d       = S_FINISH;
            end else begin
              ctl_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            ctl_o.nop = 1'b1;
            state_d   = S_FINISH;
          end
        endcase
      end
      S_POP: begin
        // popped slot number is out of the stack RAM now
        ctl_o.store_pop = 1'b1;
        state_d         = S_FINISH;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          ctl_o.resolve = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |-> sts_i.out_free)
    else $error("result beat emitted into a busy output register");
`endif

endmodule

`default_nettype wire

[rtl/ssa_dp.sv]
// Datapath: slot and free-stack RAMs, counters, key scan and result register.
`default_nettype none

module ssa_dp
  import ssa_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int SECTORS_EACH = 8,
  parameter int KEY_BITS     = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ssa_in_t  in_data_i,
  input  wire logic     cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  input  wire logic     out_stall_i,
  output logic          out_valid_o,
  output ssa_out_t      out_data_o,
  input  wire ssa_ctl_t ctl_i,
  output ssa_sts_t      sts_o
);

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TAG_W   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int ENTRY_W = TAG_W + 32 + 1;

  function automatic logic [10:0] sector_of(input logic [SLOT_W-1:0] slot);
    logic [31:0] prod;
    prod = 32'(slot) * 32'(SECTORS_EACH);
    return prod[10:0];
  endfunction

  // control state
  logic [8:0]       slot_limit_q;
  logic [CNT_W-1:0] free_depth_q;
  logic [CNT_W-1:0] issued_q;
  logic [31:0]      order_cnt_q;
  logic             out_valid_q;
  logic             rd_run_q;
  logic             v1_q;
  logic             v2_q;
  logic             best_found_q;

  // payload
  ssa_cmd_e          cmd_q;
  logic [TAG_W-1:0]  key_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic [SLOT_W-1:0] idx1_q;
  logic [SLOT_W-1:0] idx2_q;
  logic              m2_q;
  logic [31:0]       age2_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [31:0]       best_age_q;
  ssa_status_e       res_status_q;
  logic [10:0]       res_sector_q;
  ssa_out_t          out_data_q;

  // RAM ports
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr;
  logic [ENTRY_W-1:0] slot_wdata;
  logic [ENTRY_W-1:0] slot_rdata;
  logic               fs_we;
  logic [SLOT_W-1:0]  fs_raddr;
  logic [SLOT_W-1:0]  fs_rdata;
  logic [CNT_W-1:0]   fd_dec;

  logic              can_push;
  logic              rd_last;
  logic [TAG_W-1:0]  rd_tag;
  logic [31:0]       rd_order;
  logic              rd_use;
  logic              better;
  logic [SLOT_W-1:0] new_slot;

  assign fd_dec   = free_depth_q - CNT_W'(1);
  assign fs_raddr = fd_dec[SLOT_W-1:0];
  assign can_push = (free_depth_q != CNT_W'(SLOTS));
  assign rd_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == issued_q);

  assign rd_tag   = slot_rdata[TAG_W-1:0];
  assign rd_order = slot_rdata[TAG_W +: 32];
  assign rd_use   = slot_rdata[TAG_W+32];

  assign better   = v2_q && m2_q && (!best_found_q || (age2_q > best_age_q));
  assign new_slot = ctl_i.issue ? issued_q[SLOT_W-1:0] : fs_rdata;

  // slot RAM write: store marks in use with a fresh stamp, release clears the flag
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = new_slot;
    slot_wdata = {1'b1, order_cnt_q, key_q};
    if (ctl_i.issue || ctl_i.store_pop) begin
      slot_we = 1'b1;
    end else if (ctl_i.resolve && best_found_q) begin
      slot_we    = 1'b1;
      slot_waddr = best_idx_q;
      slot_wdata = {1'b0, order_cnt_q, key_q};
    end
  end

  assign fs_we = ctl_i.resolve && best_found_q && can_push;

  ssa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(rd_idx_q),
    .rdata_o(slot_rdata)
  );

  ssa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (fs_we),
    .waddr_i(free_depth_q[SLOT_W-1:0]),
    .wdata_i(best_idx_q),
    .raddr_i(fs_raddr),
    .rdata_o(fs_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= 9'd256;
      free_depth_q <= '0;
      issued_q     <= '0;
      order_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
      rd_run_q     <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slot_limit_q <= cfg_wdata_i;
      end
      if (ctl_i.pop) begin
        free_depth_q <= fd_dec;
      end else if (fs_we) begin
        free_depth_q <= free_depth_q + CNT_W'(1);
      end
      if (ctl_i.issue) begin
        issued_q <= issued_q + CNT_W'(1);
      end
      if (ctl_i.issue || ctl_i.store_pop) begin
        order_cnt_q <= order_cnt_q + 32'd1;
      end
      // scan pipeline: address, compare, pick oldest
      if (ctl_i.scan_start) begin
        rd_run_q <= 1'b1;
      end else if (rd_run_q && rd_last) begin
        rd_run_q <= 1'b0;
      end
      v1_q <= rd_run_q;
      v2_q <= v1_q;
      if (ctl_i.scan_start) begin
        best_found_q <= 1'b0;
      end else if (better) begin
        best_found_q <= 1'b1;
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= ssa_cmd_e'(in_data_i.command);
      key_q <= in_data_i.page_key[TAG_W-1:0];
    end
    if (ctl_i.scan_start) begin
      rd_idx_q <= '0;
    end else if (rd_run_q && !rd_last) begin
      rd_idx_q <= rd_idx_q + SLOT_W'(1);
    end
    idx1_q <= rd_idx_q;
    idx2_q <= idx1_q;
    m2_q   <= rd_use && (rd_tag == key_q);
    age2_q <= order_cnt_q - rd_order;
    if (better) begin
      best_idx_q <= idx2_q;
      best_age_q <= age2_q;
    end
    if (ctl_i.issue || ctl_i.store_pop) begin
      res_status_q <= ST_OK;
      res_sector_q <= sector_of(new_slot);
    end else if (ctl_i.full) begin
      res_status_q <= ST_FULL;
      res_sector_q <= '0;
    end else if (ctl_i.missing) begin
      res_status_q <= ST_MISSING;
      res_sector_q <= '0;
    end else if (ctl_i.nop) begin
      res_status_q <= ST_OK;
      res_sector_q <= '0;
    end else if (ctl_i.resolve) begin
      if (best_found_q) begin
        res_status_q <= ST_OK;
        res_sector_q <= (cmd_q == CMD_LOAD) ? sector_of(best_idx_q) : 11'd0;
      end else begin
        res_status_q <= ST_MISSING;
        res_sector_q <= '0;
      end
    end
    if (ctl_i.emit) begin
      out_data_q.status       <= res_status_q;
      out_data_q.start_sector <= res_sector_q;
    end
  end

  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.free_empty  = (free_depth_q == '0);
    sts_o.can_issue   = (32'(issued_q) < 32'(slot_limit_q)) && (32'(issued_q) < 32'(SLOTS));
    sts_o.none_issued = (issued_q == '0);
    sts_o.scan_done   = !rd_run_q && !v1_q && !v2_q;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_free_within_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_depth_q <= issued_q)
    else $error("free stack deeper than the issued slot count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_run_q |-> (CNT_W'(rd_idx_q) < issued_q))
    else $error("key scan reads a never-issued slot");

  a_stamp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.issue || ctl_i.store_pop) |=> (order_cnt_q == $past(order_cnt_q) + 32'd1))
    else $error("store stamp did not advance");
`endif

endmodule

`default_nettype wire

[rtl/swap_slot_allocator.sv]
// Swap slot allocator top level: sequencer plus datapath, one request at a time.
// Store: reuses a released slot popped off the stack RAM, else issues a new slot below the limit.
// Load/delete: one-slot-per-cycle key scan over the issued slots, skipped when none are issued.
// The next request is taken in the cycle after the result is loaded into the output register;
// a stalled result beat holds off the input.
// Reset clears counters and control only, no clearing pass; requests taken right after reset.
`default_nettype none

module swap_slot_allocator
  import ssa_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int SECTORS_EACH = 8,
  parameter int KEY_BITS     = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire ssa_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output ssa_out_t        out_data_o
);

  ssa_ctl_t ctl;
  ssa_sts_t sts;

  ssa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  ssa_dp #(
    .SLOTS       (SLOTS),
    .SECTORS_EACH(SECTORS_EACH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .ctl_i      (ctl),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

[bench/swap_slot_allocator_tb.sv]
// Self-checking bench for the swap slot allocator: directed rows, then randomised phases.
`timescale 1ns / 1ps

module swap_slot_allocator_tb;
  import ssa_pkg::*;

  localparam int POOL_SLOTS       = 256;
  localparam int SLOT_SECTORS     = 8;
  localparam int KEY_POOL_SIZE    = 24;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 300;

  typedef struct packed {
    ssa_cmd_e    cmd;
    logic [31:0] key;
    logic        pinned;
    ssa_status_e status;
    logic [10:0] sector;
  } directed_row_t;

  typedef struct {
    bit       pinned;
    ssa_out_t res;
  } pinned_res_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  logic [8:0] cfg_wdata;
  logic     in_valid;
  logic     in_stall;
  ssa_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ssa_out_t out_data;

  bit quiet;
  bit long_hold_asked;
  bit long_hold_done;
  int err_count;

  logic [31:0] key_pool [KEY_POOL_SIZE];

  // shadow of the allocator state
  logic [31:0] slot_key   [POOL_SLOTS];
  bit          slot_busy  [POOL_SLOTS];
  logic [31:0] slot_stamp [POOL_SLOTS];
  logic [7:0]  free_slots [POOL_SLOTS];
  int unsigned free_count;
  int unsigned issued_slots;
  logic [31:0] store_seq;
  logic [8:0]  slot_limit;

  ssa_out_t    pending_results [$];
  pinned_res_t pinned_q [$];

  // limit is 2 during these rows
  directed_row_t directed_rows [18] = '{
    '{CMD_LOAD,   32'h0000_0000, 1'b1, ST_MISSING, 11'd0},
    '{CMD_DELETE, 32'hFFFF_FFFF, 1'b1, ST_MISSING, 11'd0},
    '{CMD_STORE,  32'h0000_0000, 1'b1, ST_OK,      11'd0},
    '{CMD_STORE,  32'hFFFF_FFFF, 1'b1, ST_OK,      11'd8},
    '{CMD_STORE,  32'h5A5A_5A5A, 1'b1, ST_FULL,    11'd0},
    '{CMD_NONE,   32'hA5A5_A5A5, 1'b1, ST_OK,      11'd0},
    '{CMD_LOAD,   32'hFFFF_FFFF, 1'b0, ST_OK,      11'd0},
    '{CMD_STORE,  32'h0000_0000, 1'b0, ST_OK,      11'd0},
    '{CMD_LOAD,   32'h0000_0000, 1'b0, ST_OK,      11'd0},
    '{CMD_DELETE, 32'h0000_0000, 1'b0, ST_OK,      11'd0},
    '{CMD_STORE,  32'h0000_0007, 1'b0, ST_OK,      11'd0},
    '{CMD_STORE,  32'h0000_0007, 1'b0, ST_OK,      11'd0},
    '{CMD_STORE,  32'h0000_0009, 1'b1, ST_FULL,    11'd0},
    '{CMD_DELETE, 32'h0000_0007, 1'b0, ST_OK,      11'd0},
    '{CMD_LOAD,   32'h0000_0007, 1'b0, ST_OK,      11'd0},
    '{CMD_LOAD,   32'h0000_0007, 1'b1, ST_MISSING, 11'd0},
    '{CMD_NONE,   32'h0000_0000, 1'b1, ST_OK,      11'd0},
    '{CMD_DELETE, 32'h8000_0000, 1'b1, ST_MISSING, 11'd0}
  };

  swap_slot_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic ssa_out_t predict_slot_op(ssa_in_t req);
    ssa_out_t    res;
    int unsigned slot;
    int unsigned cap;
    logic [31:0] age;
    logic [31:0] best_age;
    bit          hit;
    res.status       = ST_OK;
    res.start_sector = '0;
    slot             = 0;
    best_age         = '0;
    hit              = 1'b0;
    case (ssa_cmd_e'(req.command))
      CMD_STORE: begin
        cap = (slot_limit < POOL_SLOTS) ? slot_limit : POOL_SLOTS;
        if (free_count > 0) begin
          free_count--;
          slot = free_slots[free_count];
          hit  = 1'b1;
        end else if (issued_slots < cap) begin
          slot = issued_slots;
          issued_slots++;
          hit  = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
        if (hit) begin
          slot_key[slot]   = req.page_key;
          slot_busy[slot]  = 1'b1;
          slot_stamp[slot] = store_seq;
          store_seq        = store_seq + 1;
          res.start_sector = 11'(slot * SLOT_SECTORS);
        end
      end
      CMD_LOAD, CMD_DELETE: begin
        // oldest store wins on duplicate keys; age wraps modulo 2^32
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (slot_busy[i] && slot_key[i] == req.page_key) begin
            age = store_seq - slot_stamp[i];
            if (!hit || age > best_age) begin
              hit      = 1'b1;
              slot     = i;
              best_age = age;
            end
          end
        end
        if (!hit) begin
          res.status = ST_MISSING;
        end else begin
          if (req.command == CMD_LOAD) res.start_sector = 11'(slot * SLOT_SECTORS);
          slot_busy[slot] = 1'b0;
          if (free_count < POOL_SLOTS) begin
            free_slots[free_count] = 8'(slot);
            free_count++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // tracks config, predicts on accepted requests, checks result beats
  always @(posedge clk_i) begin
    ssa_out_t    want;
    pinned_res_t pin;
    if (rst_ni) begin
      if (cfg_we) slot_limit = cfg_wdata;
      if (in_valid && !in_stall) begin
        want = predict_slot_op(in_data);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.pinned) want = pin.res;
        end
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d, start_sector %0d",
                 out_data.status, out_data.start_sector);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.start_sector !== want.start_sector) begin
            $error("start_sector: expected %0d, actual %0d",
                   want.start_sector, out_data.start_sector);
            err_count++;
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_asked && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        out_stall      <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input ssa_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic idle_sender();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // sampled on the falling edge so the monitor's pop has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_slot_limit(input logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int n_items, input int store_pct);
    ssa_in_t item;
    int      pick;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < store_pct)  item.command = CMD_STORE;
      else if (pick < 97)    item.command = $urandom_range(0, 1) ? CMD_LOAD : CMD_DELETE;
      else                   item.command = CMD_NONE;
      // mostly a small key set so loads find what was stored
      if ($urandom_range(0, 99) < 85) item.page_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      else                            item.page_key = $urandom();
      send_item(item);
      idle_sender();
    end
  endtask

  initial begin
    directed_row_t row;
    pinned_res_t   pin;
    ssa_in_t       item;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    slot_limit   = 9'd256;
    free_count   = 0;
    issued_slots = 0;
    store_seq    = '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_slot_limit(9'd2);
    foreach (directed_rows[i]) begin
      row                  = directed_rows[i];
      pin.pinned           = row.pinned;
      pin.res.status       = row.status;
      pin.res.start_sector = row.sector;
      pinned_q.push_back(pin);
      item.command  = row.cmd;
      item.page_key = row.key;
      send_item(item);
      idle_sender();
    end
    drain();

    // limit below issued count: only reuse of released slots
    write_slot_limit(9'd0);
    random_phase(100, 50);
    drain();
    write_slot_limit(9'd1);
    random_phase(60, 50);
    drain();
    // limit above the pool, store heavy so the pool fills up
    write_slot_limit(9'd511);
    random_phase(250, 80);
    drain();
    random_phase(250, 75);
    drain();
    write_slot_limit(9'd300);
    long_hold_asked = 1'b1;
    random_phase(200, 50);
    drain();
    write_slot_limit(9'd20);
    random_phase(200, 45);
    drain();
    write_slot_limit(9'd256);
    random_phase(120, 55);
    quiet = 1'b1;
    random_phase(120, 55);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/ssa_pkg.sv
rtl/ssa_ram.sv
rtl/ssa_ctrl.sv
rtl/ssa_dp.sv
rtl/swap_slot_allocator.sv
bench/swap_slot_allocator_tb.sv
